/* rtl/gwpi_pkg.sv */
// ----------------------------------------------------------------------------
// gwpi_pkg: shared types and field arithmetic for the word inverse block.
// Holds the GF(2^8) multiply used by the shared multiplier unit.
// ----------------------------------------------------------------------------
`default_nettype none
package gwpi_pkg;

	localparam logic [7:0] FIELD_POLY_LOW = 8'h1B;
	localparam logic [7:0] ONE_BYTE = 8'h01;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQ   = 5'b00010,
		ST_CUBE = 5'b00100,
		ST_SINV = 5'b01000,
		ST_SCL  = 5'b10000
	} state_t;

	// Product of two field elements, reduced by the AES polynomial.
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] r;
		r = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ x;
			x = x[7] ? ({x[6:0], 1'b0} ^ FIELD_POLY_LOW) : {x[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/gf256_word_poly_inverse.sv */
// ----------------------------------------------------------------------------
// gf256_word_poly_inverse: inverse of a four-byte word modulo x^4+1.
// One shared GF(2^8) multiplier computes b = a^3 * (s^4)^-1, s = a(1).
// Steps in order: square, cube, exponent-ladder and scale products; a word
// with a(1) = 0 skips them and gives a zero result with has_inverse low.
// The block takes no new word until its output beat is taken (in_stall stays
// high from acceptance until the beat is taken), so an output stall holds off
// the next word. Reset clears the sequencer, output valid and all registers.
// ----------------------------------------------------------------------------
`default_nettype none
module gf256_word_poly_inverse (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] coef_x3,
	input  wire logic [7:0] coef_x2,
	input  wire logic [7:0] coef_x1,
	input  wire logic [7:0] coef_x0,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      inv_x3,
	output logic [7:0]      inv_x2,
	output logic [7:0]      inv_x1,
	output logic [7:0]      inv_x0,
	output logic            has_inverse
);

	gwpi_pkg::state_t state_q;
	logic [7:0] a_q [4];
	logic [7:0] sq_q [4];
	logic [7:0] cube_q [4];
	logic [7:0] acc_q;
	logic [7:0] s_q;
	logic [7:0] p_q;
	logic [3:0] cnt_q;
	logic       busy_q;

	logic [7:0] op_a;
	logic [7:0] op_b;
	logic [7:0] prod;
	logic [1:0] k_idx;
	logic [1:0] i_idx;
	logic [1:0] j_idx;
	logic [7:0] s_in;

	assign k_idx = cnt_q[3:2];
	assign i_idx = cnt_q[1:0];
	assign j_idx = k_idx - i_idx;
	assign s_in = coef_x3 ^ coef_x2 ^ coef_x1 ^ coef_x0;
	assign in_stall = busy_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = 8'h00;
		op_b = 8'h00;
		case (state_q)
			gwpi_pkg::ST_SQ: begin
				op_a = a_q[i_idx];
				op_b = a_q[j_idx];
			end
			gwpi_pkg::ST_CUBE: begin
				op_a = sq_q[i_idx];
				op_b = a_q[j_idx];
			end
			gwpi_pkg::ST_SINV: begin
				// Ladder for s^-4: alternate folding p into acc and squaring p.
				op_a = p_q;
				op_b = cnt_q[0] ? p_q : acc_q;
			end
			gwpi_pkg::ST_SCL: begin
				op_a = cube_q[cnt_q[1:0]];
				op_b = acc_q;
			end
			default: begin
				op_a = 8'h00;
				op_b = 8'h00;
			end
		endcase
	end

	assign prod = gwpi_pkg::gf_mul(op_a, op_b);

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gwpi_pkg::ST_IDLE;
			busy_q      <= 1'b0;
			out_valid   <= 1'b0;
			cnt_q       <= '0;
			acc_q       <= 8'h00;
			s_q         <= 8'h00;
			p_q         <= 8'h00;
			inv_x3      <= 8'h00;
			inv_x2      <= 8'h00;
			inv_x1      <= 8'h00;
			inv_x0      <= 8'h00;
			has_inverse <= 1'b0;
			for (int n = 0; n < 4; n++) begin
				a_q[n]    <= 8'h00;
				sq_q[n]   <= 8'h00;
				cube_q[n] <= 8'h00;
			end
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
				busy_q    <= 1'b0;
			end
			case (state_q)
				gwpi_pkg::ST_IDLE: begin
					if (in_valid && !busy_q) begin
						busy_q <= 1'b1;
						a_q[3] <= coef_x3;
						a_q[2] <= coef_x2;
						a_q[1] <= coef_x1;
						a_q[0] <= coef_x0;
						s_q    <= s_in;
						acc_q  <= 8'h00;
						cnt_q  <= '0;
						if (s_in == 8'h00) begin
							out_valid   <= 1'b1;
							inv_x3      <= 8'h00;
							inv_x2      <= 8'h00;
							inv_x1      <= 8'h00;
							inv_x0      <= 8'h00;
							has_inverse <= 1'b0;
						end else begin
							state_q <= gwpi_pkg::ST_SQ;
						end
					end
				end
				gwpi_pkg::ST_SQ, gwpi_pkg::ST_CUBE: begin
					if (i_idx == 2'd3) begin
						if (state_q == gwpi_pkg::ST_SQ) sq_q[k_idx] <= acc_q ^ prod;
						else cube_q[k_idx] <= acc_q ^ prod;
						// The ladder after the cube starts with acc holding 1.
						acc_q <= (cnt_q == 4'd15 && state_q == gwpi_pkg::ST_CUBE)
							? gwpi_pkg::ONE_BYTE : 8'h00;
					end else begin
						acc_q <= acc_q ^ prod;
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= (state_q == gwpi_pkg::ST_SQ) ? gwpi_pkg::ST_CUBE
						                                       : gwpi_pkg::ST_SINV;
						// s starts the ladder.
						p_q <= s_q;
					end
				end
				gwpi_pkg::ST_SINV: begin
					// Even steps fold p into acc, odd steps square p; p runs s..s^128.
					// s^-4 = s^251 takes every power but s^4, skipped at step four.
					if (cnt_q[0]) p_q <= prod;
					else if (cnt_q != 4'd4) acc_q <= prod;
					if (cnt_q == 4'd14) begin
						state_q <= gwpi_pkg::ST_SCL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				gwpi_pkg::ST_SCL: begin
					case (cnt_q[1:0])
						2'd0: inv_x0 <= prod;
						2'd1: inv_x1 <= prod;
						2'd2: inv_x2 <= prod;
						default: inv_x3 <= prod;
					endcase
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q[1:0] == 2'd3) begin
						has_inverse <= 1'b1;
						out_valid   <= 1'b1;
						state_q     <= gwpi_pkg::ST_IDLE;
					end
				end
				default: state_q <= gwpi_pkg::ST_IDLE;
			endcase
		end
	end

	// Checks on the sequencer.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gwpi_pkg::ST_IDLE) |-> in_stall)
		else $error("block took a beat while working");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");
	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_inverse) |->
		(inv_x0 == 8'h00 && inv_x1 == 8'h00 && inv_x2 == 8'h00 && inv_x3 == 8'h00))
		else $error("nonzero result without inverse");

endmodule
`default_nettype wire
